// ===== rtl/arwc_pkg.sv =====
// Shared types and constants for the anti-replay window check block.
// Holds the verdict codes, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package arwc_pkg;

	localparam int SEQ_W       = 64;
	localparam int SLOT_W      = 4;
	localparam int SLOT_EN_W   = 16;
	localparam int MAX_JUMP_W  = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;

	// Reset value of the maximum forward advance register.
	localparam logic [MAX_JUMP_W-1:0] MAX_JUMP_RESET = 32'd1048576;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_ENABLE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_JUMP    = 1'b1;

	// Item kinds.
	localparam logic KIND_CHECK = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_FRESH  = 2'd0,
		VERDICT_REPLAY = 2'd1,
		VERDICT_JUMP   = 2'd2
	} verdict_t;

	// Control outcome of one item: whether the window is written, its started flag, and the verdict.
	typedef struct packed {
		logic     wr_en;
		logic     started;
		verdict_t verdict;
	} win_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/arwc_window_mem.sv =====
// Window storage: per-window started flags in flip-flops, highest sequence and
// bitmap in a memory with a registered read and write-to-read bypass.
// Depends on arwc_pkg.
`default_nettype none

module arwc_window_mem
	import arwc_pkg::*;
#(
	parameter int NWIN        = 32,
	parameter int WW          = 5,
	parameter int WINDOW_BITS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [WW-1:0]          rd_addr,
	input  wire logic [WW-1:0]          flag_addr,
	input  wire logic                   wr_en,
	input  wire logic [WW-1:0]          wr_addr,
	input  wire logic                   wr_started,
	input  wire logic [SEQ_W-1:0]       wr_highest,
	input  wire logic [WINDOW_BITS-1:0] wr_bitmap,
	output logic                        flag_started,
	output logic [SEQ_W-1:0]            rd_highest_s1,
	output logic [WINDOW_BITS-1:0]      rd_bitmap_s1
);

	logic [NWIN-1:0]        started_q;
	logic [SEQ_W-1:0]       highest_mem [NWIN];
	logic [WINDOW_BITS-1:0] bitmap_mem  [NWIN];

	// A window with a clear started flag ignores the memory contents, so the
	// flags alone carry the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
		end else if (wr_en) begin
			started_q[wr_addr] <= wr_started;
		end
	end

	assign flag_started = started_q[flag_addr];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			highest_mem[wr_addr] <= wr_highest;
			bitmap_mem[wr_addr]  <= wr_bitmap;
		end
	end

	// The write landing at this edge is newer than the memory word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_highest_s1 <= wr_highest;
				rd_bitmap_s1  <= wr_bitmap;
			end else begin
				rd_highest_s1 <= highest_mem[rd_addr];
				rd_bitmap_s1  <= bitmap_mem[rd_addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/arwc_update.sv =====
// Combinational window update: verdict and next window contents for one item.
// Depends on arwc_pkg.
`default_nettype none

module arwc_update
	import arwc_pkg::*;
#(
	parameter int WINDOW_BITS = 64
) (
	input  wire logic                   kind,
	input  wire logic                   in_range,
	input  wire logic                   enabled,
	input  wire logic                   started,
	input  wire logic [SEQ_W-1:0]       seq,
	input  wire logic [SEQ_W-1:0]       highest,
	input  wire logic [WINDOW_BITS-1:0] bitmap,
	input  wire logic [MAX_JUMP_W-1:0]  max_jump,
	output win_ctrl_t                   ctrl,
	output logic [SEQ_W-1:0]            new_highest,
	output logic [WINDOW_BITS-1:0]      new_bitmap
);

	localparam int SHW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
	localparam logic [SEQ_W-1:0] WB_SEQ = SEQ_W'(WINDOW_BITS);

	logic [SEQ_W:0]         diff;
	logic [SEQ_W-1:0]       adv;
	logic [SEQ_W-1:0]       behind;
	logic                   ahead;
	logic [WINDOW_BITS-1:0] one_bit;
	logic [WINDOW_BITS-1:0] seen_bit;

	assign diff     = {1'b0, seq} - {1'b0, highest};
	assign adv      = diff[SEQ_W-1:0];
	assign behind   = ~adv + SEQ_W'(1);
	assign ahead    = !diff[SEQ_W] && (adv != '0);
	assign one_bit  = WINDOW_BITS'(1);
	assign seen_bit = one_bit << behind[SHW-1:0];

	always_comb begin
		ctrl.wr_en   = 1'b0;
		ctrl.started = 1'b1;
		ctrl.verdict = VERDICT_FRESH;
		new_highest  = highest;
		new_bitmap   = bitmap;
		if (!in_range) begin
			ctrl.verdict = VERDICT_REPLAY;
		end else if (kind == KIND_CLEAR) begin
			ctrl.wr_en   = 1'b1;
			ctrl.started = 1'b0;
		end else if (!enabled) begin
			ctrl.verdict = VERDICT_REPLAY;
		end else if (!started) begin
			ctrl.wr_en  = 1'b1;
			new_highest = seq;
			new_bitmap  = one_bit;
		end else if (ahead) begin
			if (adv > {{(SEQ_W-MAX_JUMP_W){1'b0}}, max_jump}) begin
				ctrl.verdict = VERDICT_JUMP;
			end else begin
				ctrl.wr_en  = 1'b1;
				new_highest = seq;
				if (adv >= WB_SEQ) begin
					new_bitmap = one_bit;
				end else begin
					new_bitmap = (bitmap << adv[SHW-1:0]) | one_bit;
				end
			end
		end else if (behind >= WB_SEQ) begin
			ctrl.verdict = VERDICT_REPLAY;
		end else if ((bitmap & seen_bit) != '0) begin
			ctrl.verdict = VERDICT_REPLAY;
		end else begin
			ctrl.wr_en = 1'b1;
			new_bitmap = bitmap | seen_bit;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/anti_replay_window_check_core.sv =====
// Top level of the anti-replay window check block.
// Instantiates arwc_window_mem and arwc_update; depends on arwc_pkg.
`default_nettype none

// How to use this block:
// Requests enter on the command channel: a request is taken at a rising clock
// edge where start is high and busy is low. Busy stays low, so a request can
// be issued in every cycle. Each request carries kind, slot_index, stream_sel
// and seq_number; a clear request resets the window of its slot and stream.
// Each request gives exactly one verdict. The verdict sits on the verdict port,
// marked by done for one cycle, once the result register is loaded: the edge
// that takes the request loads the input stage and reads the window memory,
// and the next edge stores the verdict and writes the updated window.
// Throughput is one request per cycle, set by the single read-modify-write of
// the window memory; a read that hits the window being written that same edge
// takes the new data through a bypass.
// Configuration writes use the cfg channel (cfg_ready is always high): index 0
// is the slot enable mask, index 1 the largest accepted forward jump. Write
// them only while no request is in flight.
// Reset clears the started flags of all windows, the enable mask, and the
// pipeline valid bits, and restores the jump limit; it takes effect at once.
// The receiver cannot stall: done is a strobe and must be taken when seen.
module anti_replay_window_check_core
	import arwc_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int WINDOW_BITS = 64,
	parameter int STREAMS     = 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   kind,
	input  wire logic [SLOT_W-1:0]      slot_index,
	input  wire logic                   stream_sel,
	input  wire logic [SEQ_W-1:0]       seq_number,
	output logic                        done,
	output logic [1:0]                  verdict,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int NWIN = SLOTS * STREAMS;
	localparam int WW   = (NWIN > 1) ? $clog2(NWIN) : 1;

	logic                   accept;
	logic [WW-1:0]          win_in;
	logic                   in_range_in;

	logic [SLOT_EN_W-1:0]   slot_enable_q;
	logic [MAX_JUMP_W-1:0]  max_jump_q;

	logic                   valid_s1;
	logic                   kind_s1;
	logic                   in_range_s1;
	logic                   enabled_s1;
	logic [WW-1:0]          win_s1;
	logic [SEQ_W-1:0]       seq_s1;

	logic                   started_rd;
	logic [SEQ_W-1:0]       highest_s1;
	logic [WINDOW_BITS-1:0] bitmap_s1;

	win_ctrl_t              ctrl;
	logic                   wr_en;
	logic [SEQ_W-1:0]       new_highest;
	logic [WINDOW_BITS-1:0] new_bitmap;

	logic                   done_q;
	verdict_t               verdict_q;

	// Every cycle can take a request, and configuration is always accepted.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Window number is slot times streams plus stream; out-of-range
	// selections never write the storage.
	assign win_in      = WW'(32'(slot_index) * STREAMS + 32'(stream_sel));
	assign in_range_in = (32'(slot_index) < SLOTS) && (32'(stream_sel) < STREAMS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_enable_q <= '0;
			max_jump_q    <= MAX_JUMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SLOT_ENABLE: slot_enable_q <= cfg_data[SLOT_EN_W-1:0];
				REG_MAX_JUMP:    max_jump_q    <= cfg_data[MAX_JUMP_W-1:0];
				default:         ;
			endcase
		end
	end

	// Input stage. The enable bit is sampled here, which matches the model only if the user
	// changes configuration while the block is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			in_range_s1 <= in_range_in;
			enabled_s1  <= slot_enable_q[slot_index];
			win_s1      <= win_in;
			seq_s1      <= seq_number;
		end
	end

	assign wr_en = valid_s1 && ctrl.wr_en;

	arwc_window_mem #(
		.NWIN        (NWIN),
		.WW          (WW),
		.WINDOW_BITS (WINDOW_BITS)
	) u_mem (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (accept),
		.rd_addr       (win_in),
		.flag_addr     (win_s1),
		.wr_en         (wr_en),
		.wr_addr       (win_s1),
		.wr_started    (ctrl.started),
		.wr_highest    (new_highest),
		.wr_bitmap     (new_bitmap),
		.flag_started  (started_rd),
		.rd_highest_s1 (highest_s1),
		.rd_bitmap_s1  (bitmap_s1)
	);

	arwc_update #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_update (
		.kind        (kind_s1),
		.in_range    (in_range_s1),
		.enabled     (enabled_s1),
		.started     (started_rd),
		.seq         (seq_s1),
		.highest     (highest_s1),
		.bitmap      (bitmap_s1),
		.max_jump    (max_jump_q),
		.ctrl        (ctrl),
		.new_highest (new_highest),
		.new_bitmap  (new_bitmap)
	);

	// Result register: one strobe per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			verdict_q <= ctrl.verdict;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

`ifndef SYNTHESIS
	// Every verdict strobe traces back to a request taken through the input stage and the result register.
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("verdict strobe without a request");

	// A jump verdict never modifies the window.
	a_jump_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctrl.verdict == VERDICT_JUMP) |-> !wr_en)
		else $error("window written on jump verdict");

	// A clear of a valid window always reports fresh.
	a_clear_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == KIND_CLEAR && in_range_s1)
			|=> (done && verdict == VERDICT_FRESH))
		else $error("clear request not reported fresh");

	// Out-of-range windows are never written.
	a_range_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_range_s1) |-> !wr_en)
		else $error("write to out-of-range window");

	// A disabled slot never yields a fresh check verdict.
	a_disabled_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == KIND_CHECK && !enabled_s1)
			|=> (verdict == VERDICT_REPLAY))
		else $error("disabled slot passed a check");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for anti_replay_window_check_core.
// Drives check and clear requests and register writes, and predicts each verdict.
// Depends on arwc_pkg and the RTL of the block.
`default_nettype none

module tb
	import arwc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Geometry of the block as built here; the predictor uses the same numbers.
	localparam int NUM_SLOTS   = 16;
	localparam int WIN_BITS    = 64;
	localparam int NUM_STREAMS = 2;
	localparam int NUM_WINDOWS = NUM_SLOTS * NUM_STREAMS;

	// Cycles the link must stay quiet before the sender counts the block as drained.
	// A verdict follows its request through the input stage and the result register.
	localparam int SETTLE_CYCLES = 4;
	// Cycles with no accepted request, write or verdict before the run is abandoned.
	// The slowest correct run never idles longer than a sender gap plus a drain.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_REQUESTS = 123;

	// One step of the sender's plan: a request, a register write, or a pause that
	// lasts until every verdict already owed has come back.
	typedef enum logic [1:0] {
		STEP_REQUEST,
		STEP_WRITE,
		STEP_PAUSE
	} step_op_t;

	typedef struct {
		step_op_t                 op;
		int unsigned              gap;
		logic                     kind;
		logic [SLOT_W-1:0]        slot;
		logic                     stream;
		logic [SEQ_W-1:0]         seq;
		logic [CFG_INDEX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]    reg_value;
	} plan_step_t;

	// What the predictor expects for one accepted request.
	typedef struct {
		verdict_t verdict;
		int       req_no;
		logic     kind;
		logic [SLOT_W-1:0] slot;
		logic     stream;
		logic [SEQ_W-1:0] seq;
	} owed_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   start = 1'b0;
	logic                   busy;
	logic                   kind = KIND_CHECK;
	logic [SLOT_W-1:0]      slot_index = '0;
	logic                   stream_sel = 1'b0;
	logic [SEQ_W-1:0]       seq_number = '0;
	logic                   done;
	logic [1:0]             verdict;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SLOT_ENABLE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	anti_replay_window_check_core #(
		.SLOTS       (NUM_SLOTS),
		.WINDOW_BITS (WIN_BITS),
		.STREAMS     (NUM_STREAMS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.slot_index (slot_index),
		.stream_sel (stream_sel),
		.seq_number (seq_number),
		.done       (done),
		.verdict    (verdict),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sender plan, filled by the stimulus block and drained by the driver.
	plan_step_t request_plan[$];
	// Verdicts owed by the block, oldest first.
	owed_verdict_t owed_verdicts[$];

	// Predictor copy of the registers and of every replay window.
	logic [SLOT_EN_W-1:0]  en_mask;
	logic [MAX_JUMP_W-1:0] jump_limit;
	logic                  win_started [NUM_WINDOWS];
	logic [SEQ_W-1:0]      win_high    [NUM_WINDOWS];
	logic [WIN_BITS-1:0]   win_map     [NUM_WINDOWS];

	// Request and verdict counts, updated with nonblocking assignments so that the
	// driver sees settled values at every edge.
	int requests_taken;
	int verdicts_seen;

	int  fail_count = 0;
	int  idle_cycles = 0;
	logic steady = 1'b0;

	// Driver state.
	plan_step_t  cur_step;
	logic        step_active = 1'b0;
	int unsigned hold_left = 0;
	int          quiet_cycles = 0;

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	// Works out the verdict of one request and applies its effect on the window.
	// A clear always resets the window, even for a disabled slot. A check on a
	// disabled slot is rejected. The first check anchors the window; a later one moves
	// it forward, is refused as a jump, marks one bitmap bit, or is refused as a replay.
	function automatic verdict_t judge_packet(input logic k, input logic [SLOT_W-1:0] s,
			input logic st, input logic [SEQ_W-1:0] sq);
		int w;
		logic [SEQ_W-1:0] adv;
		logic [SEQ_W-1:0] lag;
		w = int'(s) * NUM_STREAMS + int'(st);
		if (k == KIND_CLEAR) begin
			win_started[w] = 1'b0;
			win_high[w] = '0;
			win_map[w] = '0;
			return VERDICT_FRESH;
		end
		if (!en_mask[s]) begin
			return VERDICT_REPLAY;
		end
		if (!win_started[w]) begin
			win_started[w] = 1'b1;
			win_high[w] = sq;
			win_map[w] = 64'd1;
			return VERDICT_FRESH;
		end
		if (sq > win_high[w]) begin
			adv = sq - win_high[w];
			if (adv > SEQ_W'(jump_limit)) begin
				return VERDICT_JUMP;
			end
			// An advance of a whole window or more leaves only the new packet.
			if (adv >= SEQ_W'(WIN_BITS)) begin
				win_map[w] = 64'd1;
			end else begin
				win_map[w] = (win_map[w] << adv) | 64'd1;
			end
			win_high[w] = sq;
			return VERDICT_FRESH;
		end
		// At or below the highest sequence: too old, already seen, or a late fill.
		lag = win_high[w] - sq;
		if (lag >= SEQ_W'(WIN_BITS)) begin
			return VERDICT_REPLAY;
		end
		if (win_map[w][lag[5:0]]) begin
			return VERDICT_REPLAY;
		end
		win_map[w][lag[5:0]] = 1'b1;
		return VERDICT_FRESH;
	endfunction

	// Plan-building helpers. The sender gap is drawn per step unless a steady
	// stretch is running.
	task automatic plan_request(input logic k, input logic [SLOT_W-1:0] s, input logic st,
			input logic [SEQ_W-1:0] sq);
		plan_step_t p;
		p = '{op: STEP_REQUEST, gap: steady ? 0 : $urandom_range(0, 6), kind: k, slot: s,
			stream: st, seq: sq, reg_index: REG_SLOT_ENABLE, reg_value: '0};
		request_plan.push_back(p);
	endtask

	task automatic plan_pause();
		plan_step_t p;
		p = '{op: STEP_PAUSE, gap: 0, kind: KIND_CHECK, slot: '0, stream: 1'b0, seq: '0,
			reg_index: REG_SLOT_ENABLE, reg_value: '0};
		request_plan.push_back(p);
	endtask

	// Registers are only written with nothing in flight, so every write is
	// preceded by a pause.
	task automatic plan_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		plan_step_t p;
		plan_pause();
		p = '{op: STEP_WRITE, gap: steady ? 0 : $urandom_range(0, 6), kind: KIND_CHECK,
			slot: '0, stream: 1'b0, seq: '0, reg_index: idx, reg_value: value};
		request_plan.push_back(p);
	endtask

	// Driver: takes steps off the plan one at a time. A step is finished at the
	// edge that accepts its request or write; a pause is finished once the count
	// of verdicts has matched the count of requests and the block counts as drained.
	// Each port gets at most one nonblocking assignment per edge, and start exactly one,
	// so start stays high without a glitch across back-to-back requests.
	always @(posedge clk) begin : driver
		logic fire_req;
		logic fire_cfg;
		fire_req = 1'b0;
		fire_cfg = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			step_active = 1'b0;
			hold_left = 0;
			quiet_cycles = 0;
		end else begin
			if ((start && !busy) || (cfg_valid && cfg_ready)) begin
				step_active = 1'b0;
			end
			quiet_cycles = (requests_taken == verdicts_seen) ? quiet_cycles + 1 : 0;
			if (!step_active && request_plan.size() != 0) begin
				cur_step = request_plan.pop_front();
				step_active = 1'b1;
				hold_left = cur_step.gap;
				// A request accepted at this very edge is not yet counted, so a
				// pause starts counting quiet cycles from zero.
				if (cur_step.op == STEP_PAUSE) begin
					quiet_cycles = 0;
				end
			end
			if (step_active) begin
				if (hold_left > 0) begin
					hold_left--;
				end else begin
					case (cur_step.op)
						STEP_REQUEST: fire_req = 1'b1;
						STEP_WRITE:   fire_cfg = 1'b1;
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								step_active = 1'b0;
							end
						end
					endcase
				end
			end
			start <= fire_req;
			cfg_valid <= fire_cfg;
			if (fire_req) begin
				kind <= cur_step.kind;
				slot_index <= cur_step.slot;
				stream_sel <= cur_step.stream;
				seq_number <= cur_step.seq;
			end
			if (fire_cfg) begin
				cfg_index <= cur_step.reg_index;
				cfg_data <= cur_step.reg_value;
			end
		end
	end

	// Monitor: compares each verdict strobe with the oldest owed verdict, then
	// applies register writes and predicts the verdict of every accepted request.
	// Verdicts are retired before new requests are added, which keeps the order
	// right when a request and an older verdict share an edge.
	always @(posedge clk) begin : monitor
		owed_verdict_t owed;
		if (!arst_n) begin
			en_mask = '0;
			jump_limit = MAX_JUMP_RESET;
			for (int w = 0; w < NUM_WINDOWS; w++) begin
				win_started[w] = 1'b0;
				win_high[w] = '0;
				win_map[w] = '0;
			end
			requests_taken <= 0;
			verdicts_seen <= 0;
		end else begin
			if (done) begin
				verdicts_seen <= verdicts_seen + 1;
				if (owed_verdicts.size() == 0) begin
					log_failure($sformatf("verdict %0d with no request outstanding", verdict));
				end else begin
					owed = owed_verdicts.pop_front();
					if (verdict !== owed.verdict) begin
						log_failure($sformatf(
							"request %0d kind %0b slot %0d stream %0d seq %h: verdict exp %0d got %0d",
							owed.req_no, owed.kind, owed.slot, owed.stream, owed.seq,
							owed.verdict, verdict));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SLOT_ENABLE: en_mask = cfg_data[SLOT_EN_W-1:0];
					REG_MAX_JUMP:    jump_limit = cfg_data[MAX_JUMP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				owed.verdict = judge_packet(kind, slot_index, stream_sel, seq_number);
				owed.req_no = requests_taken;
				owed.kind = kind;
				owed.slot = slot_index;
				owed.stream = stream_sel;
				owed.seq = seq_number;
				owed_verdicts.push_back(owed);
				requests_taken <= requests_taken + 1;
			end
		end
	end

	// Watchdog: a run that stops moving is a failure.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: a directed opening, then random phases, each under its own
	// register setting. The plan is built at time zero, before reset ends.
	initial begin : stimulus
		logic [SEQ_W-1:0]      seq_cursor [NUM_WINDOWS];
		logic [SEQ_W-1:0]      base;
		logic [SEQ_W-1:0]      sq;
		logic [SLOT_EN_W-1:0]  mask;
		logic [MAX_JUMP_W-1:0] limit;
		logic [SLOT_W-1:0]     s;
		logic                  st;
		int                    w;
		int                    count;

		// Directed part. After reset every slot is disabled: a check is refused
		// and a clear still succeeds.
		plan_request(KIND_CHECK, 4'd3, 1'b0, 64'd5);
		plan_request(KIND_CLEAR, 4'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		// Enable every slot but 14; the jump limit keeps its reset value.
		plan_write(REG_SLOT_ENABLE, 32'h0000_BFFF);
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd0);      // anchors the window
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd0);      // equal to highest: replay
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd63);     // shift by 63
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd0);      // oldest bit, already seen
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd1);      // late fill inside window
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd127);    // advance of a full window
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd63);     // just too old
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd1048703); // advance exactly at the limit
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd1048704); // wait: advance of one, fresh
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd2097281); // one past the limit: jump
		plan_request(KIND_CHECK, 4'd14, 1'b1, 64'd9);     // disabled slot
		plan_request(KIND_CHECK, 4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		plan_request(KIND_CHECK, 4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
		plan_request(KIND_CHECK, 4'd15, 1'b1, 64'd0);     // far behind the top
		plan_request(KIND_CLEAR, 4'd15, 1'b1, 64'd0);
		plan_request(KIND_CHECK, 4'd15, 1'b1, 64'd0);     // re-anchors after the clear
		// A zero limit refuses any forward move but still allows late fills.
		plan_write(REG_MAX_JUMP, 32'd0);
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd1048705);
		plan_request(KIND_CHECK, 4'd0, 1'b0, 64'd1048703);
		// The widest limit.
		plan_write(REG_MAX_JUMP, 32'hFFFF_FFFF);
		plan_request(KIND_CHECK, 4'd1, 1'b0, 64'd0);
		plan_request(KIND_CHECK, 4'd1, 1'b0, 64'h0000_0000_FFFF_FFFF);
		plan_request(KIND_CHECK, 4'd1, 1'b0, 64'h0000_0001_FFFF_FFFF);
		plan_request(KIND_CHECK, 4'd1, 1'b1, 64'h8000_0000_0000_0000);

		// Random part. Most checks stay near a per-window cursor so that windows
		// are driven through shifts, fills, replays and jumps; a few are noise.
		for (int i = 0; i < NUM_WINDOWS; i++) begin
			seq_cursor[i] = {$urandom, $urandom};
		end
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin mask = 16'hFFFF; limit = 32'hFFFF_FFFF; end
				1: begin mask = 16'h0000; limit = 32'd0; end
				2: begin mask = 16'hFFFF; limit = 32'd0; end
				3: begin mask = SLOT_EN_W'($urandom) | 16'h000F; limit = 32'd1; end
				4: begin mask = SLOT_EN_W'($urandom) | 16'h000F; limit = 32'd63; end
				5: begin mask = SLOT_EN_W'($urandom) | 16'h000F; limit = 32'd64; end
				6: begin mask = SLOT_EN_W'($urandom) | 16'h000F; limit = 32'd65; end
				7: begin mask = SLOT_EN_W'($urandom) | 16'h000F; limit = MAX_JUMP_RESET; end
				default: begin mask = SLOT_EN_W'($urandom); limit = $urandom; end
			endcase
			plan_write(REG_SLOT_ENABLE, CFG_DATA_W'(mask));
			plan_write(REG_MAX_JUMP, CFG_DATA_W'(limit));
			// With every slot disabled almost everything is refused, so that
			// phase is kept short.
			count = (mask == '0) ? 40 : PHASE_REQUESTS;
			for (int n = 0; n < count; n++) begin
				if (n % 40 == 0) begin
					steady = ($urandom_range(0, 2) == 0);
				end
				s = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, 3))
					: SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
				st = 1'($urandom_range(0, 1));
				w = int'(s) * NUM_STREAMS + int'(st);
				base = seq_cursor[w];
				if ($urandom_range(0, 99) < 3) begin
					plan_request(KIND_CLEAR, s, st, {$urandom, $urandom});
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2: sq = base + $urandom_range(1, 4);
						3:       sq = base + $urandom_range(60, 68);
						4:       sq = base + limit;
						5:       sq = base + limit + 1;
						6, 7:    sq = base - $urandom_range(0, 70);
						8:       sq = base;
						default: sq = {$urandom, $urandom};
					endcase
					if (sq > base && sq - base <= SEQ_W'(limit)) begin
						seq_cursor[w] = sq;
					end
					plan_request(KIND_CHECK, s, st, sq);
				end
				// Now and then the sender waits for every verdict to come back.
				if ($urandom_range(0, 99) == 0) begin
					plan_pause();
				end
			end
		end
		plan_pause();

		// Reset is released once, at a clock edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The closing pause ends only after every owed verdict has arrived.
		@(posedge clk);
		while (request_plan.size() != 0 || step_active) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (owed_verdicts.size() != 0) begin
			fail_count += owed_verdicts.size();
			$display("%0d verdicts never arrived", owed_verdicts.size());
		end
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
